>>> rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 box blur unit.
// ----------------------------------------------------------------------------
package bb3_pkg;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Width of the configuration registers and the row/column counters.
	localparam int CNT_W = 11;

	// Request type codes.
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// Fractional bits of the reciprocal used for the rounded mean.
	localparam int RECIP_SHIFT = 18;

	// Classification of one window step, decided by the front end.
	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic c_ge1;
		logic c_ge2;
		logic emit_a;
		logic emit_b;
		logic done;
	} q_flags_t;

	// One queue transaction: the new window column and its classification.
	typedef struct packed {
		logic [23:0] top;
		logic [23:0] mid;
		logic [23:0] bot;
		q_flags_t    flags;
	} q_entry_t;

	// Reciprocal ceil(2^18 / (2*n)); exact floor division for dividends below 2^13.
	function automatic logic [17:0] recip(input logic [3:0] n);
		logic [17:0] m;
		case (n)
			4'd1:    m = 18'd131072;
			4'd2:    m = 18'd65536;
			4'd3:    m = 18'd43691;
			4'd4:    m = 18'd32768;
			4'd5:    m = 18'd26215;
			4'd6:    m = 18'd21846;
			4'd7:    m = 18'd18725;
			4'd8:    m = 18'd16384;
			4'd9:    m = 18'd14564;
			default: m = 18'd0;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/bb3_front.sv
// ----------------------------------------------------------------------------
// bb3_front
// Accepts pixels and drain ticks, tracks the raster position, reads and
// updates the line buffers, and hands one classified column per step on.
// ----------------------------------------------------------------------------
module bb3_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [bb3_pkg::CNT_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [7:0]                  red_in,
	input  logic [7:0]                  green_in,
	input  logic [7:0]                  blue_in,
	output logic                        q_push,
	output bb3_pkg::q_entry_t           q_entry,
	input  logic                        q_full
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [bb3_pkg::CNT_W-1:0] width_q, height_q, row_q, col_q, drain_q;
	logic [bb3_pkg::CNT_W-1:0] w_eff, h_eff, c_raw, c, r;
	logic                      drain, process, last, accept;
	logic [AW-1:0]             addr;
	bb3_pkg::q_flags_t         flags;

	logic                      valid_s1, wr_s1, byp_s1;
	logic [AW-1:0]             addr_s1;
	logic [23:0]               pix_s1;
	logic [47:0]               rd_s1, byp_data_s1, rd_eff;
	bb3_pkg::q_flags_t         flags_s1;

	logic [47:0]               mem [MAX_WIDTH];

	// Effective frame size and position of the incoming transaction.
	always_comb begin
		w_eff = width_q;
		if (width_q == '0) begin
			w_eff = 11'd1;
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = 11'(MAX_WIDTH);
		end
		h_eff = (height_q == '0) ? 11'd1 : height_q;
		drain = (req_type == bb3_pkg::REQ_DRAIN);
		process = drain ? (row_q >= h_eff) : (row_q < h_eff);
		c_raw = drain ? drain_q : col_q;
		c = (c_raw >= w_eff) ? (w_eff - 11'd1) : c_raw;
		r = drain ? h_eff : row_q;
		last = (c == (w_eff - 11'd1));
		addr = AW'(c);
		flags.top_ok = (r >= 11'd2);
		flags.bot_ok = (r < h_eff);
		flags.c_ge1  = (c >= 11'd1);
		flags.c_ge2  = (c >= 11'd2);
		flags.emit_a = (r != '0) && (c >= 11'd1);
		flags.emit_b = (r != '0) && last;
		flags.done   = drain && last;
	end

	assign in_ready = !valid_s1 || !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = valid_s1 && !q_full;

	// Forward a write still in flight to the same column.
	assign rd_eff = byp_s1 ? byp_data_s1 : rd_s1;

	assign q_entry.top   = rd_eff[47:24];
	assign q_entry.mid   = rd_eff[23:0];
	assign q_entry.bot   = pix_s1;
	assign q_entry.flags = flags_s1;

	// Configuration registers and raster counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 11'd1024;
			row_q    <= '0;
			col_q    <= '0;
			drain_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bb3_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				bb3_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			row_q   <= '0;
			col_q   <= '0;
			drain_q <= '0;
		end else if (accept && process) begin
			if (drain) begin
				if (last) begin
					drain_q <= '0;
					row_q   <= '0;
					col_q   <= '0;
				end else begin
					drain_q <= c + 11'd1;
				end
			end else if (last) begin
				col_q <= '0;
				row_q <= row_q + 11'd1;
			end else begin
				col_q <= c + 11'd1;
			end
		end
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && process) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (accept && process) begin
			pix_s1      <= drain ? 24'd0 : {red_in, green_in, blue_in};
			addr_s1     <= addr;
			wr_s1       <= !drain;
			flags_s1    <= flags;
			byp_s1      <= valid_s1 && wr_s1 && (addr_s1 == addr);
			byp_data_s1 <= {rd_eff[23:0], pix_s1};
		end
	end

	// Line buffers: older row in the upper half, newer row in the lower half.
	always_ff @(posedge clk) begin
		if (accept && process) begin
			rd_s1 <= mem[addr];
		end
		if (q_push && wr_s1) begin
			mem[addr_s1] <= {rd_eff[23:0], pix_s1};
		end
	end

endmodule

>>> rtl/bb3_fifo.sv
// ----------------------------------------------------------------------------
// bb3_fifo
// Two-entry queue between the front end and the averaging back end.
// ----------------------------------------------------------------------------
module bb3_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bb3_pkg::q_entry_t din,
	output logic              full,
	input  logic              pop,
	output bb3_pkg::q_entry_t dout,
	output logic              empty
);

	bb3_pkg::q_entry_t mem_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

>>> rtl/bb3_back.sv
// ----------------------------------------------------------------------------
// bb3_back
// Shifts the 3x3 window, sums the clipped neighborhoods and gives up to two
// rounded means per step through a registered output.
// ----------------------------------------------------------------------------
module bb3_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  bb3_pkg::q_entry_t q_entry,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        red_out,
	output logic [7:0]        green_out,
	output logic [7:0]        blue_out,
	output logic              last_in_run,
	output logic              frame_done
);

	logic [23:0] win_q [3][3];
	logic [23:0] nw [3][3];
	logic [9:0]  cs [3][3];
	logic [11:0] sum_a [3];
	logic [11:0] sum_b [3];
	logic [1:0]  rows, cols_a, cols_b;
	logic [3:0]  n_a, n_b;

	logic        a_v_s1, b_v_s1, a_last_s1, a_done_s1, b_done_s1;
	logic [12:0] xa_s1 [3];
	logic [12:0] xb_s1 [3];
	logic [3:0]  na_s1, nb_s1;

	logic        take, busy;
	logic [12:0] x_sel [3];
	logic [3:0]  n_sel;
	logic [17:0] m_sel;
	logic [30:0] prod [3];
	logic [7:0]  quo [3];
	bb3_pkg::q_flags_t f;

	assign f = q_entry.flags;

	// Next window and clipped column sums per channel.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw[i][0] = win_q[i][1];
			nw[i][1] = win_q[i][2];
		end
		nw[0][2] = q_entry.top;
		nw[1][2] = q_entry.mid;
		nw[2][2] = q_entry.bot;
		for (int k = 0; k < 3; k++) begin
			for (int ch = 0; ch < 3; ch++) begin
				cs[k][ch] = (f.top_ok ? 10'(nw[0][k][8*ch +: 8]) : 10'd0)
					+ 10'(nw[1][k][8*ch +: 8])
					+ (f.bot_ok ? 10'(nw[2][k][8*ch +: 8]) : 10'd0);
			end
		end
		for (int ch = 0; ch < 3; ch++) begin
			sum_a[ch] = 12'(cs[2][ch]) + 12'(cs[1][ch])
				+ (f.c_ge2 ? 12'(cs[0][ch]) : 12'd0);
			sum_b[ch] = 12'(cs[2][ch]) + (f.c_ge1 ? 12'(cs[1][ch]) : 12'd0);
		end
		rows   = 2'd1 + 2'(f.top_ok) + 2'(f.bot_ok);
		cols_a = f.c_ge2 ? 2'd3 : 2'd2;
		cols_b = f.c_ge1 ? 2'd2 : 2'd1;
		n_a    = 4'(rows * cols_a);
		n_b    = 4'(rows * cols_b);
	end

	// Output selection: the first result of a step goes before the second.
	assign take  = (!out_valid || out_ready) && (a_v_s1 || b_v_s1);
	assign busy  = a_v_s1 || b_v_s1;
	assign q_pop = !q_empty && (!busy || (take && !(a_v_s1 && b_v_s1)));

	always_comb begin
		n_sel = a_v_s1 ? na_s1 : nb_s1;
		m_sel = bb3_pkg::recip(n_sel);
		for (int ch = 0; ch < 3; ch++) begin
			x_sel[ch] = a_v_s1 ? xa_s1[ch] : xb_s1[ch];
			prod[ch]  = 31'(x_sel[ch]) * 31'(m_sel);
			quo[ch]   = prod[ch][bb3_pkg::RECIP_SHIFT +: 8];
		end
	end

	// Window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					win_q[i][k] <= '0;
				end
			end
		end else if (q_pop) begin
			win_q <= nw;
		end
	end

	// Pending results of the current step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_s1 <= 1'b0;
			b_v_s1 <= 1'b0;
		end else if (q_pop) begin
			a_v_s1 <= f.emit_a;
			b_v_s1 <= f.emit_b;
		end else if (take) begin
			if (a_v_s1) begin
				a_v_s1 <= 1'b0;
			end else begin
				b_v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int ch = 0; ch < 3; ch++) begin
				xa_s1[ch] <= 13'({sum_a[ch], 1'b0}) + 13'(n_a);
				xb_s1[ch] <= 13'({sum_b[ch], 1'b0}) + 13'(n_b);
			end
			na_s1     <= n_a;
			nb_s1     <= n_b;
			a_last_s1 <= !f.emit_b;
			a_done_s1 <= f.done && !f.emit_b;
			b_done_s1 <= f.done;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			red_out     <= quo[2];
			green_out   <= quo[1];
			blue_out    <= quo[0];
			last_in_run <= a_v_s1 ? a_last_s1 : 1'b1;
			frame_done  <= a_v_s1 ? a_done_s1 : b_done_s1;
		end
	end

endmodule

>>> rtl/box_blur_3x3_unit.sv
// Path: front-end stage register, queue, pending-result registers, then the output register.
// Throughput: one transaction per cycle while the queue has room; a row end with two results
// holds the queue; the single output register carries one result per cycle unless stalled.
// The line buffers take one read and one write per cycle, with forwarding for a 1-pixel row.
// Reset: asynchronous, active low; registers return to 1024x1024, counters and window to zero,
// line buffer contents stay undefined until written.
// ----------------------------------------------------------------------------
// box_blur_3x3_unit
// Streaming 3x3 box blur over an RGB frame in raster order.
// ----------------------------------------------------------------------------
module box_blur_3x3_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [bb3_pkg::CNT_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      req_type,
	input  logic [7:0]                red_in,
	input  logic [7:0]                green_in,
	input  logic [7:0]                blue_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                red_out,
	output logic [7:0]                green_out,
	output logic [7:0]                blue_out,
	output logic                      last_in_run,
	output logic                      frame_done
);

	logic              q_push, q_full, q_pop, q_empty;
	bb3_pkg::q_entry_t q_din, q_dout;

	bb3_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.q_push    (q_push),
		.q_entry   (q_din),
		.q_full    (q_full)
	);

	bb3_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	bb3_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_entry     (q_dout),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.last_in_run (last_in_run),
		.frame_done  (frame_done)
	);

`ifndef SYNTHESIS
	// The last pixel of the frame is always the final result of its transaction.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last_in_run)
		else $error("frame_done without last_in_run");

	// The queue is never full and empty at once.
	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue level inconsistent");

	// Input stalls only when the queue backs up.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_full)
		else $error("input stalled with room in the queue");
`endif

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for box_blur_3x3_unit. A queue of pixel and drain
// transactions feeds a bursty driver. A stalling receiver takes the results,
// and a clocked monitor compares each one, in order, with a software blur model
// kept in step with the accepted transactions.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_MAX = 1024;

	// One input transaction and one blurred result.
	typedef struct packed {
		logic       req;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
		logic       done;
	} blur_px_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [0:0]                cfg_index = bb3_pkg::CFG_IMAGE_WIDTH;
	logic [bb3_pkg::CNT_W-1:0] cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      req_type = bb3_pkg::REQ_PIXEL;
	logic [7:0]                red_in = '0;
	logic [7:0]                green_in = '0;
	logic [7:0]                blue_in = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [7:0]                red_out;
	logic [7:0]                green_out;
	logic [7:0]                blue_out;
	logic                      last_in_run;
	logic                      frame_done;

	pix_req_t pending_pix[$];
	blur_px_t expected_px[$];
	logic     offer_pending = 1'b0;
	int       errors = 0;
	int       item_count = 0;
	int       hold_req = 0;

	// Software copy of the blur datapath.
	logic [23:0]               line_old[LINE_MAX];
	logic [23:0]               line_new[LINE_MAX];
	logic [23:0]               win[3][3];
	int                        row_cnt = 0;
	int                        col_cnt = 0;
	int                        drain_cnt = 0;
	logic [bb3_pkg::CNT_W-1:0] width_reg = 11'd1024;
	logic [bb3_pkg::CNT_W-1:0] height_reg = 11'd1024;

	box_blur_3x3_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.last_in_run(last_in_run), .frame_done(frame_done)
	);

	always #5 clk = ~clk;

	function automatic int eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > LINE_MAX) return LINE_MAX;
		return width_reg;
	endfunction

	function automatic int eff_height();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	// Rounded mean over window columns lo..2, edge rows masked off.
	function automatic blur_px_t window_mean(int lo, bit top_ok, bit bot_ok);
		int sum_r, sum_g, sum_b, cnt;
		blur_px_t px;
		sum_r = 0; sum_g = 0; sum_b = 0; cnt = 0;
		for (int r = 0; r < 3; r++) begin
			if ((r == 0 && !top_ok) || (r == 2 && !bot_ok))
				continue;
			for (int k = lo; k < 3; k++) begin
				sum_r += win[r][k][23:16];
				sum_g += win[r][k][15:8];
				sum_b += win[r][k][7:0];
				cnt++;
			end
		end
		if (cnt == 0)
			cnt = 1;
		px.red   = 8'((2 * sum_r + cnt) / (2 * cnt));
		px.green = 8'((2 * sum_g + cnt) / (2 * cnt));
		px.blue  = 8'((2 * sum_b + cnt) / (2 * cnt));
		px.last  = 1'b0;
		px.done  = 1'b0;
		return px;
	endfunction

	// Advance the blur model by one accepted transaction and queue its results.
	task automatic blur_step(logic req, logic [7:0] r_in, logic [7:0] g_in, logic [7:0] b_in);
		int w, h, rr, c, n;
		logic [23:0] pix;
		blur_px_t res[2];
		w = eff_width();
		h = eff_height();
		pix = '0;
		n = 0;
		if (req == bb3_pkg::REQ_PIXEL) begin
			if (row_cnt >= h)
				return;
			rr = row_cnt;
			c = col_cnt;
			pix = {r_in, g_in, b_in};
		end else begin
			if (row_cnt < h)
				return;
			rr = h;
			c = drain_cnt;
		end
		if (c >= w)
			c = w - 1;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = line_old[c];
		win[1][2] = line_new[c];
		win[2][2] = pix;
		if (req == bb3_pkg::REQ_PIXEL) begin
			line_old[c] = line_new[c];
			line_new[c] = pix;
		end
		if (rr >= 1) begin
			if (c >= 1) begin
				res[n] = window_mean((c >= 2) ? 0 : 1, rr >= 2, rr < h);
				n++;
			end
			if (c == w - 1) begin
				res[n] = window_mean((c >= 1) ? 1 : 2, rr >= 2, rr < h);
				n++;
			end
			if (n > 0) begin
				res[n - 1].last = 1'b1;
				if (req == bb3_pkg::REQ_DRAIN && c == w - 1)
					res[n - 1].done = 1'b1;
			end
			for (int i = 0; i < n; i++)
				expected_px.push_back(res[i]);
		end
		if (req == bb3_pkg::REQ_PIXEL) begin
			if (c + 1 >= w) begin
				col_cnt = 0;
				row_cnt = (row_cnt + 1) & 11'h7FF;
			end else begin
				col_cnt = c + 1;
			end
		end else if (c + 1 >= w) begin
			drain_cnt = 0;
			row_cnt = 0;
			col_cnt = 0;
		end else begin
			drain_cnt = c + 1;
		end
	endtask

	task automatic report_mismatch(string what, int exp_v, int got_v);
		$display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
		errors++;
	endtask

	// Sender: bursts of random length with random gaps.
	int burst_left = 8;
	int gap_left = 0;
	always @(negedge clk) begin
		pix_req_t it;
		if (arst_n && !offer_pending) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_pix.size() > 0) begin
				it = pending_pix.pop_front();
				req_type <= it.req;
				red_in <= it.red;
				green_in <= it.green;
				blue_in <= it.blue;
				in_valid <= 1'b1;
				offer_pending <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Input transaction accepted: update the model.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			blur_step(req_type, red_in, green_in, blue_in);
			offer_pending <= 1'b0;
		end
	end

	// Receiver: stall pattern that switches among three modes, plus long holds.
	int hold_left = 0;
	int rx_cycle = 0;
	int rx_mode = 0;
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 50 == 0)
				rx_mode = $urandom_range(0, 2);
			case (rx_mode)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					out_ready <= ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	// Monitor: compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		blur_px_t exp_px;
		if (arst_n && out_valid && out_ready) begin
			if (expected_px.size() == 0) begin
				report_mismatch("unexpected result", 0, 1);
			end else begin
				exp_px = expected_px.pop_front();
				if (red_out !== exp_px.red)
					report_mismatch("red_out", exp_px.red, red_out);
				if (green_out !== exp_px.green)
					report_mismatch("green_out", exp_px.green, green_out);
				if (blue_out !== exp_px.blue)
					report_mismatch("blue_out", exp_px.blue, blue_out);
				if (last_in_run !== exp_px.last)
					report_mismatch("last_in_run", exp_px.last, last_in_run);
				if (frame_done !== exp_px.done)
					report_mismatch("frame_done", exp_px.done, frame_done);
			end
		end
	end

	// Wait until everything queued is accepted and every result has arrived.
	task automatic wait_idle();
		while (pending_pix.size() > 0 || offer_pending || in_valid || expected_px.size() > 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(bb3_pkg::cfg_reg_t idx, logic [bb3_pkg::CNT_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == bb3_pkg::CFG_IMAGE_WIDTH)
			width_reg = value;
		else
			height_reg = value;
		row_cnt = 0;
		col_cnt = 0;
		drain_cnt = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_size(logic [bb3_pkg::CNT_W-1:0] w, logic [bb3_pkg::CNT_W-1:0] h);
		wait_idle();
		write_reg(bb3_pkg::CFG_IMAGE_WIDTH, w);
		write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, h);
	endtask

	function automatic pix_req_t make_pixel(int fill, int idx);
		pix_req_t p;
		p.req = bb3_pkg::REQ_PIXEL;
		case (fill)
			1: p.red = 8'hFF;
			2: p.red = 8'h00;
			3: p.red = (idx % 2) ? 8'hFF : 8'h00;
			default: p.red = 8'($urandom);
		endcase
		p.green = (fill == 0) ? 8'($urandom) : p.red;
		p.blue  = (fill == 0) ? 8'($urandom) : ~p.red;
		return p;
	endfunction

	// Queue one frame: pixels in raster order, then a row of drain ticks.
	// Noise adds drain ticks inside the frame and pixels inside the drain,
	// both of which the block must ignore. A cut frame stops early.
	task automatic queue_frame(int w, int h, int fill, bit noisy, int cut);
		pix_req_t p;
		int total;
		total = w * h;
		if (cut > 0 && cut < total)
			total = cut;
		for (int i = 0; i < total; i++) begin
			if (noisy && $urandom_range(0, 9) == 0) begin
				p = make_pixel(0, 0);
				p.req = bb3_pkg::REQ_DRAIN;
				pending_pix.push_back(p);
			end
			pending_pix.push_back(make_pixel(fill, i));
			item_count++;
		end
		if (cut > 0 && cut < w * h)
			return;
		for (int i = 0; i < w; i++) begin
			if (noisy && $urandom_range(0, 7) == 0)
				pending_pix.push_back(make_pixel(0, 0));
			p = make_pixel(0, 0);
			p.req = bb3_pkg::REQ_DRAIN;
			pending_pix.push_back(p);
			item_count++;
		end
	endtask

	// Stimulus and end of run.
	initial begin
		int w, h;
		bit need_cfg;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed frames: extremes, degenerate sizes and ignored transactions.
		set_size(11'd3, 11'd3);
		queue_frame(3, 3, 1, 1'b0, 0);
		queue_frame(3, 3, 3, 1'b1, 0);
		set_size(11'd1, 11'd1);
		queue_frame(1, 1, 2, 1'b1, 0);
		set_size(11'd0, 11'd0);
		queue_frame(1, 1, 1, 1'b0, 0);
		set_size(11'd1, 11'd3);
		queue_frame(1, 3, 0, 1'b0, 0);
		set_size(11'd4, 11'd1);
		queue_frame(4, 1, 3, 1'b0, 0);
		set_size(11'd2, 11'h7FF);
		queue_frame(2, 2047, 0, 1'b0, 5);

		// Long receiver hold while a full frame is offered: the block backs up.
		set_size(11'd12, 11'd6);
		hold_req = 300;
		queue_frame(12, 6, 0, 1'b0, 0);

		// Random frames, mostly small, with noise and cut frames mixed in.
		need_cfg = 1'b1;
		while (item_count < 750) begin
			if (need_cfg || $urandom_range(0, 9) < 7) begin
				w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				h = $urandom_range(1, 6);
				set_size(11'(w), 11'(h));
			end
			need_cfg = 1'b0;
			if ($urandom_range(0, 9) == 0) begin
				queue_frame(w, h, 0, 1'b1, $urandom_range(1, w * h));
				need_cfg = 1'b1;
			end else begin
				queue_frame(w, h, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
					$urandom_range(0, 3) == 0, 0);
			end
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

endmodule
